[hw/rtl/pwm_prescaler_period_calculator_macros.svh]
// ----------------------------------------------------------------------------
// PWM prescaler/period calculator assertion macros
// Shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PWM_PRESCALER_PERIOD_CALCULATOR_MACROS_SVH
`define PWM_PRESCALER_PERIOD_CALCULATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define PWMPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PWMPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pwmpc_pkg.sv]
// ----------------------------------------------------------------------------
// pwmpc_pkg
// Types and constants shared by the PWM prescaler/period calculator
// ----------------------------------------------------------------------------
package pwmpc_pkg;

    localparam int unsigned DIV_W       = 32;
    localparam int unsigned FIELD_W     = 16;
    localparam int unsigned TICKS_CELLS = DIV_W;
    localparam int unsigned ARR_CELLS   = FIELD_W + 1;
    localparam int unsigned REM_SHIFT   = ARR_CELLS;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef logic [DIV_W-1:0]   word_t;
    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        word_t  rem;
        word_t  dividend;
        word_t  divisor;
        word_t  quotient;
        field_t psc;
        logic   err;
    } div_stage_t;

    typedef struct packed {
        logic   status;
        field_t prescaler;
        field_t period;
    } result_t;

endpackage

[hw/rtl/pwmpc_if.sv]
// ----------------------------------------------------------------------------
// pwmpc_if
// Valid/ready channels of the PWM prescaler/period calculator
// ----------------------------------------------------------------------------
interface pwmpc_req_if;
    logic              valid;
    logic              ready;
    pwmpc_pkg::word_t  frequency_hz;

    modport source (output valid, output frequency_hz, input ready);
    modport sink   (input valid, input frequency_hz, output ready);
endinterface

interface pwmpc_rsp_if;
    logic              valid;
    logic              ready;
    logic              status;
    pwmpc_pkg::field_t prescaler;
    pwmpc_pkg::field_t period;

    modport source (output valid, output status, output prescaler, output period,
                    input ready);
    modport sink   (input valid, input status, input prescaler, input period,
                    output ready);
endinterface

interface pwmpc_cfg_if;
    logic              valid;
    logic              ready;
    pwmpc_pkg::word_t  clock_rate_hz;

    modport source (output valid, output clock_rate_hz, input ready);
    modport sink   (input valid, input clock_rate_hz, output ready);
endinterface

[hw/rtl/pwmpc_div_cell.sv]
// ----------------------------------------------------------------------------
// pwmpc_div_cell
// One restoring division step: shifts in a dividend bit, yields one quotient bit
// ----------------------------------------------------------------------------
module pwmpc_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  pwmpc_pkg::div_stage_t in_data,
    output logic                  out_valid,
    output pwmpc_pkg::div_stage_t out_data
);
    import pwmpc_pkg::*;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;
    div_stage_t     data_next;
    div_stage_t     data_reg;
    logic           valid_reg;

    always_comb
    begin
        shifted = {in_data.rem, in_data.dividend[DIV_W-1]};
        diff    = shifted - {1'b0, in_data.divisor};
        ge      = (shifted >= {1'b0, in_data.divisor});

        data_next          = in_data;
        data_next.rem      = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        data_next.dividend = {in_data.dividend[DIV_W-2:0], 1'b0};
        data_next.quotient = {in_data.quotient[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/pwmpc_prep.sv]
// ----------------------------------------------------------------------------
// pwmpc_prep
// Turns the tick count into the prescaler and sets up the period division
// ----------------------------------------------------------------------------
module pwmpc_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  pwmpc_pkg::div_stage_t in_data,
    output logic                  out_valid,
    output pwmpc_pkg::div_stage_t out_data
);
    import pwmpc_pkg::*;

    word_t          ticks;
    word_t          ticks_m1;
    field_t         psc;
    logic [FIELD_W:0] psc_p1;
    div_stage_t     data_next;
    div_stage_t     data_reg;
    logic           valid_reg;

    always_comb
    begin
        ticks    = in_data.quotient;
        ticks_m1 = ticks - word_t'(1);
        psc      = ticks_m1[DIV_W-1 -: FIELD_W];
        psc_p1   = {1'b0, psc} + {{FIELD_W{1'b0}}, 1'b1};

        data_next.rem      = {{REM_SHIFT{1'b0}}, ticks[DIV_W-1:REM_SHIFT]};
        data_next.dividend = {ticks[REM_SHIFT-1:0], {(DIV_W-REM_SHIFT){1'b0}}};
        data_next.divisor  = {{(DIV_W-FIELD_W-1){1'b0}}, psc_p1};
        data_next.quotient = '0;
        data_next.psc      = psc;
        data_next.err      = in_data.err | (ticks == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/pwmpc_out_buf.sv]
// ----------------------------------------------------------------------------
// pwmpc_out_buf
// Forms the result and holds it in an output register with a skid entry
// ----------------------------------------------------------------------------
module pwmpc_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tail_valid,
    input  pwmpc_pkg::div_stage_t tail_data,
    output logic                  adv,
    pwmpc_rsp_if.source           rsp
);
    import pwmpc_pkg::*;

    logic [FIELD_W:0] arr_full;
    result_t          result;
    logic             fire;
    logic             incoming;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             load_from_skid;
    logic             load_new;
    logic             load_skid;
    result_t          out_data_reg;
    result_t          skid_data_reg;

    always_comb
    begin
        arr_full = tail_data.quotient[FIELD_W:0] - {{FIELD_W{1'b0}}, 1'b1};
        if (tail_data.err)
        begin
            result.status    = STATUS_ERR;
            result.prescaler = '0;
            result.period    = '0;
        end
        else
        begin
            result.status    = STATUS_OK;
            result.prescaler = tail_data.psc;
            result.period    = arr_full[FIELD_W-1:0];
        end
    end

    assign adv      = ~skid_valid_reg;
    assign fire     = out_valid_reg & rsp.ready;
    assign incoming = adv & tail_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_from_skid  = 1'b0;
        load_new        = 1'b0;
        load_skid       = 1'b0;
        if (!out_valid_reg || fire)
        begin
            if (skid_valid_reg)
            begin
                load_from_skid  = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                load_new       = incoming;
                out_valid_next = incoming;
            end
        end
        else if (incoming)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load_new)
        begin
            out_data_reg <= result;
        end
        if (load_skid)
        begin
            skid_data_reg <= result;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_data_reg.status;
    assign rsp.prescaler = out_data_reg.prescaler;
    assign rsp.period    = out_data_reg.period;

endmodule

[hw/rtl/pwm_prescaler_period_calculator.sv]
// ----------------------------------------------------------------------------
// pwm_prescaler_period_calculator
// Derives a 16-bit timer prescaler and auto-reload period from a PWM frequency
// ----------------------------------------------------------------------------
// usage
//   cfg: one write transaction sets clock_rate_hz (reset value 0); cfg.ready
//     is always high; write it only while no request is in flight
//   req: one transaction carries frequency_hz; rsp returns status, prescaler
//     and period for it, in request order, one rsp per req
//   path: a req transaction passes 32 tick division cells, 1 prescaler stage,
//     17 period division cells and 1 output register before its rsp
//   throughput: one request per cycle while req.ready is high; the division cell rows step in lockstep
//   stall: when rsp is held the output register keeps its result, the next one
//     lands in a skid entry, then the whole row holds and req.ready drops
//   reset: clears all valid bits and clock_rate_hz; req.ready is high after it
//   errors: zero frequency, zero clock or frequency above clock give status 1
//     with prescaler and period zero
// ----------------------------------------------------------------------------
module pwm_prescaler_period_calculator (
    input  logic        clk,
    input  logic        rst_n,
    pwmpc_req_if.sink   req,
    pwmpc_rsp_if.source rsp,
    pwmpc_cfg_if.sink   cfg
);
    import pwmpc_pkg::*;

    word_t                clock_rate_hz_reg;
    logic                 adv;
    logic [TICKS_CELLS:0] ticks_valid;
    div_stage_t           ticks_data [TICKS_CELLS+1];
    logic [ARR_CELLS:0]   arr_valid;
    div_stage_t           arr_data [ARR_CELLS+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_hz_reg <= '0;
        end
        else if (cfg.valid)
        begin
            clock_rate_hz_reg <= cfg.clock_rate_hz;
        end
    end

    assign req.ready = adv;

    always_comb
    begin
        ticks_valid[0]         = req.valid;
        ticks_data[0].rem      = '0;
        ticks_data[0].dividend = clock_rate_hz_reg;
        ticks_data[0].divisor  = req.frequency_hz;
        ticks_data[0].quotient = '0;
        ticks_data[0].psc      = '0;
        ticks_data[0].err      = (req.frequency_hz == '0);
    end

    for (genvar i = 0; i < TICKS_CELLS; i++)
    begin : g_ticks
        pwmpc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (ticks_valid[i]),
            .in_data   (ticks_data[i]),
            .out_valid (ticks_valid[i+1]),
            .out_data  (ticks_data[i+1])
        );
    end

    pwmpc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ticks_valid[TICKS_CELLS]),
        .in_data   (ticks_data[TICKS_CELLS]),
        .out_valid (arr_valid[0]),
        .out_data  (arr_data[0])
    );

    for (genvar j = 0; j < ARR_CELLS; j++)
    begin : g_arr
        pwmpc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (arr_valid[j]),
            .in_data   (arr_data[j]),
            .out_valid (arr_valid[j+1]),
            .out_data  (arr_data[j+1])
        );
    end

    pwmpc_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (arr_valid[ARR_CELLS]),
        .tail_data  (arr_data[ARR_CELLS]),
        .adv        (adv),
        .rsp        (rsp)
    );

endmodule

[hw/rtl/pwmpc_checker.sv]
// ----------------------------------------------------------------------------
// pwmpc_checker
// Port-level checks on the PWM prescaler/period calculator
// ----------------------------------------------------------------------------
`include "pwm_prescaler_period_calculator_macros.svh"

module pwmpc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_status,
    input pwmpc_pkg::field_t rsp_prescaler,
    input pwmpc_pkg::field_t rsp_period
);
    import pwmpc_pkg::*;

    // a held result stays put
    `PWMPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_prescaler) && $stable(rsp_period), "rsp changed while stalled")

    // error results carry zero fields
    `PWMPC_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_status == STATUS_ERR), (rsp_prescaler == '0) && (rsp_period == '0), "error result with nonzero fields")

    // a nonzero prescaler always leaves the period at 32767 or above
    `PWMPC_ASSERT_NOW(a_period_range, rsp_valid && (rsp_status == STATUS_OK) && (rsp_prescaler != '0), rsp_period >= 16'd32767, "period too small for nonzero prescaler")

    // req.ready only drops after a stalled result
    `PWMPC_ASSERT_NOW(a_ready_drop, $fell(req_ready), $past(rsp_valid && !rsp_ready), "req.ready dropped without rsp stall")

endmodule

bind pwm_prescaler_period_calculator pwmpc_checker u_pwmpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_prescaler (rsp.prescaler),
    .rsp_period    (rsp.period)
);

[sim/pwm_prescaler_period_calculator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_prescaler_period_calculator_tb
// Drives frequency requests through several timer clock settings, predicts the
// prescaler, period and status of each one, and checks every response in order
// under random idle cycles on both channels
// ----------------------------------------------------------------------------
module pwm_prescaler_period_calculator_tb;

    import pwmpc_pkg::*;

    localparam longint unsigned TICK_SPAN  = 65536;
    localparam longint unsigned FIELD_MAX  = 65535;
    localparam int              SETTLE     = 64;
    localparam int              HANG_LIMIT = 4000;
    localparam int              IDLE_PCT   = 21;
    localparam int              CALM_LO    = 600;
    localparam int              CALM_HI    = 800;

    typedef enum logic [1:0] {
        PLAN_FREQ,
        PLAN_CLOCK,
        PLAN_DRAIN
    } plan_kind_t;

    typedef struct {
        plan_kind_t kind;
        word_t      value;
    } plan_entry_t;

    logic clk;
    logic rst_n;

    pwmpc_req_if req_ch ();
    pwmpc_rsp_if rsp_ch ();
    pwmpc_cfg_if cfg_ch ();

    plan_entry_t freq_plan[$];
    result_t     expected_settings[$];
    word_t       clock_model;
    int          mismatch_count;
    int          freq_sent;
    int          settings_seen;
    int          quiet_cycles;
    int          hang_cycles;

    pwm_prescaler_period_calculator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    function automatic result_t derive_timer_setting(word_t clock_hz, word_t freq_hz);
        logic [63:0] ticks;
        logic [63:0] psc;
        logic [63:0] arr;
        result_t     r;
        r.status    = STATUS_ERR;
        r.prescaler = '0;
        r.period    = '0;
        if (freq_hz == 0 || clock_hz == 0)
            return r;
        ticks = 64'(clock_hz / freq_hz);
        if (ticks == 0)
            return r;
        if (ticks <= TICK_SPAN)
        begin
            psc = 0;
            arr = ticks - 1;
        end
        else
        begin
            psc = (ticks - 1) / TICK_SPAN;
            if (psc > FIELD_MAX)
                return r;
            arr = ticks / (psc + 1) - 1;
            if (arr > FIELD_MAX)
            begin
                psc = psc + 1;
                arr = ticks / (psc + 1) - 1;
            end
            if (arr > FIELD_MAX || psc > FIELD_MAX)
                return r;
        end
        r.status    = STATUS_OK;
        r.prescaler = psc[FIELD_W-1:0];
        r.period    = arr[FIELD_W-1:0];
        return r;
    endfunction

    function automatic word_t pick_frequency(word_t clock_hz);
        word_t ticks;
        int    mode;
        mode = $urandom_range(6);
        if (clock_hz == 0)
            return (mode < 3) ? word_t'($urandom) : word_t'($urandom_range(5000));
        case (mode)
            0: return $urandom;
            1: return $urandom_range(2000);
            2:
            begin
                ticks = $urandom_range(32'h0003_0000, 1);
                return clock_hz / ticks;
            end
            3:
            begin
                ticks = $urandom;
                if (ticks == 0)
                    ticks = 1;
                return clock_hz / ticks;
            end
            4: return clock_hz + $urandom_range(1000, 1);
            5:
            begin
                ticks = word_t'(TICK_SPAN + $urandom_range(8) - 4);
                return clock_hz / ticks + $urandom_range(2) - 1;
            end
            default: return clock_hz / ($urandom_range(65535, 1) * 65536 + $urandom_range(65535));
        endcase
    endfunction

    task automatic plan_freq(input word_t freq_hz);
        freq_plan.push_back('{PLAN_FREQ, freq_hz});
    endtask

    task automatic plan_clock(input word_t clock_hz);
        freq_plan.push_back('{PLAN_CLOCK, clock_hz});
    endtask

    task automatic plan_random(input word_t clock_hz, input int count);
        for (int i = 0; i < count; i++)
            plan_freq(pick_frequency(clock_hz));
    endtask

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sender: requests and clock writes, clock writes only once the pipe is empty
    always @(posedge clk or negedge rst_n)
    begin
        logic  nxt_valid;
        word_t nxt_freq;
        logic  nxt_cfg_valid;
        word_t nxt_cfg_data;
        logic  calm;
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.frequency_hz  <= '0;
            cfg_ch.valid         <= 1'b0;
            cfg_ch.clock_rate_hz <= '0;
            quiet_cycles = 0;
            freq_sent    = 0;
        end
        else
        begin
            nxt_valid     = req_ch.valid;
            nxt_freq      = req_ch.frequency_hz;
            nxt_cfg_valid = cfg_ch.valid;
            nxt_cfg_data  = cfg_ch.clock_rate_hz;
            calm          = freq_sent >= CALM_LO && freq_sent < CALM_HI;
            if (req_ch.valid && req_ch.ready)
            begin
                nxt_valid = 1'b0;
                freq_sent++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                nxt_cfg_valid = 1'b0;
            if (expected_settings.size() == 0 && !req_ch.valid && !cfg_ch.valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nxt_valid && !nxt_cfg_valid && freq_plan.size() > 0)
            begin
                case (freq_plan[0].kind)
                    PLAN_FREQ:
                    begin
                        if (calm || $urandom_range(99) >= IDLE_PCT)
                        begin
                            nxt_valid = 1'b1;
                            nxt_freq  = freq_plan[0].value;
                            void'(freq_plan.pop_front());
                        end
                        else
                            nxt_freq = $urandom;
                    end
                    PLAN_CLOCK:
                    begin
                        if (quiet_cycles >= SETTLE)
                        begin
                            nxt_cfg_valid = 1'b1;
                            nxt_cfg_data  = freq_plan[0].value;
                            void'(freq_plan.pop_front());
                            quiet_cycles = 0;
                        end
                    end
                    PLAN_DRAIN:
                    begin
                        if (quiet_cycles >= SETTLE)
                            void'(freq_plan.pop_front());
                    end
                    default: void'(freq_plan.pop_front());
                endcase
            end
            req_ch.valid         <= nxt_valid;
            req_ch.frequency_hz  <= nxt_freq;
            cfg_ch.valid         <= nxt_cfg_valid;
            cfg_ch.clock_rate_hz <= nxt_cfg_data;
        end
    end

    // receiver: predicts on each request transaction, checks each response
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    calm;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            clock_model   = '0;
            settings_seen = 0;
        end
        else
        begin
            calm = settings_seen >= CALM_LO && settings_seen < CALM_HI;
            if (cfg_ch.valid && cfg_ch.ready)
                clock_model = cfg_ch.clock_rate_hz;
            if (req_ch.valid && req_ch.ready)
                expected_settings.push_back(
                    derive_timer_setting(clock_model, req_ch.frequency_hz));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                settings_seen++;
                if (expected_settings.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t unexpected response: status %0d prescaler %0d period %0d",
                             $time, rsp_ch.status, rsp_ch.prescaler, rsp_ch.period);
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                    end
                    if (rsp_ch.prescaler !== want.prescaler)
                    begin
                        mismatch_count++;
                        $display("%0t prescaler mismatch: expected %0d actual %0d",
                                 $time, want.prescaler, rsp_ch.prescaler);
                    end
                    if (rsp_ch.period !== want.period)
                    begin
                        mismatch_count++;
                        $display("%0t period mismatch: expected %0d actual %0d",
                                 $time, want.period, rsp_ch.period);
                    end
                end
            end
            rsp_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            hang_cycles = 0;
        else
            hang_cycles++;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("%0t timeout with %0d responses outstanding",
                     $time, expected_settings.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        word_t rnd_clock;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.frequency_hz  = '0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.clock_rate_hz = '0;
        mismatch_count       = 0;
        hang_cycles          = 0;

        // timer clock still at its reset value of zero
        plan_freq(32'd0);
        plan_freq(32'd1);
        plan_freq(32'hFFFF_FFFF);
        plan_random(32'd0, 8);

        plan_clock(32'hFFFF_FFFF);
        plan_freq(32'd0);
        plan_freq(32'd1);
        plan_freq(32'd2);
        plan_freq(32'd3);
        plan_freq(32'h0000_FFFF);
        plan_freq(32'h0001_0000);
        plan_freq(32'h0001_0001);
        plan_freq(32'h7FFF_FFFF);
        plan_freq(32'h8000_0000);
        plan_freq(32'hFFFF_FFFE);
        plan_freq(32'hFFFF_FFFF);
        plan_random(32'hFFFF_FFFF, 150);

        plan_clock(32'd72_000_000);
        plan_freq(32'd72_000_000);
        plan_freq(32'd72_000_001);
        plan_freq(32'd1098);
        plan_freq(32'd1099);
        plan_freq(32'd1100);
        plan_freq(32'd1);
        plan_random(32'd72_000_000, 80);
        freq_plan.push_back('{PLAN_DRAIN, '0});
        plan_random(32'd72_000_000, 80);

        plan_clock(32'd1);
        plan_freq(32'd1);
        plan_freq(32'd2);
        plan_random(32'd1, 60);

        plan_clock(32'd0);
        plan_random(32'd0, 60);

        plan_clock(32'd65536);
        plan_random(32'd65536, 120);

        plan_clock(32'd170_000_000);
        plan_random(32'd170_000_000, 200);

        rnd_clock = $urandom;
        plan_clock(rnd_clock);
        plan_random(rnd_clock, 180);
        freq_plan.push_back('{PLAN_DRAIN, '0});
        plan_random(rnd_clock, 80);

        plan_clock(32'h8000_0000);
        plan_random(32'h8000_0000, 200);

        plan_clock(32'd131073);
        plan_random(32'd131073, 120);

        rnd_clock = $urandom;
        plan_clock(rnd_clock);
        plan_random(rnd_clock, 120);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (freq_plan.size() != 0 || req_ch.valid || cfg_ch.valid
               || expected_settings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
